>>> rtl/core/tssr_pkg.sv
// Shared types, codes and constants of the tile and sprite scanline renderer.
package tssr_pkg;

    localparam int LINE_WIDTH_DEF   = 160;
    localparam int SPRITE_COUNT_DEF = 40;

    localparam int VMEM_AW = 13;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    localparam logic [VMEM_AW-1:0] MAP_LOW_OFS  = 13'h1800;   // 0x9800
    localparam logic [VMEM_AW-1:0] MAP_HIGH_OFS = 13'h1C00;   // 0x9C00
    localparam logic [VMEM_AW-1:0] VMEM_LAST    = 13'h1FFF;

    // lcd_control bits
    localparam int LCDC_BG_EN  = 0;
    localparam int LCDC_OBJ_EN = 1;
    localparam int LCDC_MAP    = 3;
    localparam int LCDC_TILES  = 4;

    // sprite attribute bits
    localparam int ATTR_BEHIND = 7;
    localparam int ATTR_YFLIP  = 6;
    localparam int ATTR_XFLIP  = 5;
    localparam int ATTR_PAL    = 4;

    // register indexes
    localparam logic [2:0] REG_LCDC  = 3'd0;
    localparam logic [2:0] REG_SCY   = 3'd1;
    localparam logic [2:0] REG_SCX   = 3'd2;
    localparam logic [2:0] REG_BGP   = 3'd3;
    localparam logic [2:0] REG_OBP0  = 3'd4;
    localparam logic [2:0] REG_OBP1  = 3'd5;

    typedef enum logic [1:0] {
        OP_VRAM   = 2'd0,
        OP_OAM    = 2'd1,
        OP_RENDER = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_CLR,
        CMD_ACCEPT,
        CMD_BG_MAP,
        CMD_BG_LO,
        CMD_BG_HI,
        CMD_BG_WR,
        CMD_SP_Y,
        CMD_SP_X,
        CMD_SP_T,
        CMD_SP_A,
        CMD_SP_CHK,
        CMD_SP_LO,
        CMD_SP_HI,
        CMD_PX_RD,
        CMD_PX_WR,
        CMD_OUT_RD,
        CMD_OUT_CAP,
        CMD_OUT_PUSH
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        t_op  in_op;
        logic spr_en;
        logic col_last;
        logic spr_last;
        logic spr_hit;
        logic px_skip;
        logic k_last;
        logic grp_last;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/tssr_ctrl.sv
// Sequencer of the scanline renderer: clearing pass, background, sprites, readout.
module tssr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tssr_pkg::t_status i_status,
    output tssr_pkg::t_cmd    o_cmd
);

    typedef enum logic [17:0] {
        S_CLR   = 18'h00001,
        S_IDLE  = 18'h00002,
        S_BMAP  = 18'h00004,
        S_BLO   = 18'h00008,
        S_BHI   = 18'h00010,
        S_BWR   = 18'h00020,
        S_SY    = 18'h00040,
        S_SX    = 18'h00080,
        S_ST    = 18'h00100,
        S_SA    = 18'h00200,
        S_SCHK  = 18'h00400,
        S_SLO   = 18'h00800,
        S_SHI   = 18'h01000,
        S_PRD   = 18'h02000,
        S_PWR   = 18'h04000,
        S_ORD   = 18'h08000,
        S_OCAP  = 18'h10000,
        S_OPUSH = 18'h20000
    } t_state;

    t_state r_state, n_state;
    t_state spr_next;

    assign spr_next   = i_status.spr_last ? S_ORD : S_SY;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = tssr_pkg::CMD_IDLE;
        case (r_state)
            S_CLR: begin
                o_cmd = tssr_pkg::CMD_CLR;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = tssr_pkg::CMD_ACCEPT;
                    if (i_status.in_op == tssr_pkg::OP_RENDER) n_state = S_BMAP;
                end
            end
            S_BMAP: begin o_cmd = tssr_pkg::CMD_BG_MAP; n_state = S_BLO; end
            S_BLO:  begin o_cmd = tssr_pkg::CMD_BG_LO;  n_state = S_BHI; end
            S_BHI:  begin o_cmd = tssr_pkg::CMD_BG_HI;  n_state = S_BWR; end
            S_BWR: begin
                o_cmd = tssr_pkg::CMD_BG_WR;
                if (i_status.col_last) n_state = i_status.spr_en ? S_SY : S_ORD;
                else n_state = S_BMAP;
            end
            S_SY:   begin o_cmd = tssr_pkg::CMD_SP_Y; n_state = S_SX;   end
            S_SX:   begin o_cmd = tssr_pkg::CMD_SP_X; n_state = S_ST;   end
            S_ST:   begin o_cmd = tssr_pkg::CMD_SP_T; n_state = S_SA;   end
            S_SA:   begin o_cmd = tssr_pkg::CMD_SP_A; n_state = S_SCHK; end
            S_SCHK: begin
                o_cmd   = tssr_pkg::CMD_SP_CHK;
                n_state = i_status.spr_hit ? S_SLO : spr_next;
            end
            S_SLO:  begin o_cmd = tssr_pkg::CMD_SP_LO; n_state = S_SHI; end
            S_SHI:  begin o_cmd = tssr_pkg::CMD_SP_HI; n_state = S_PRD; end
            S_PRD: begin
                o_cmd = tssr_pkg::CMD_PX_RD;
                if (i_status.px_skip) n_state = i_status.k_last ? spr_next : S_PRD;
                else n_state = S_PWR;
            end
            S_PWR: begin
                o_cmd   = tssr_pkg::CMD_PX_WR;
                n_state = i_status.k_last ? spr_next : S_PRD;
            end
            S_ORD:  begin o_cmd = tssr_pkg::CMD_OUT_RD; n_state = S_OCAP; end
            S_OCAP: begin
                o_cmd   = tssr_pkg::CMD_OUT_CAP;
                n_state = i_status.k_last ? S_OPUSH : S_ORD;
            end
            S_OPUSH: begin
                o_cmd = tssr_pkg::CMD_OUT_PUSH;
                if (i_status.out_free) n_state = i_status.grp_last ? S_IDLE : S_ORD;
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end

endmodule

>>> rtl/core/tssr_datapath.sv
// Memories, configuration registers, counters and pixel logic of the renderer.
module tssr_datapath #(
    parameter int LINE_WIDTH   = tssr_pkg::LINE_WIDTH_DEF,
    parameter int SPRITE_COUNT = tssr_pkg::SPRITE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tssr_pkg::t_cmd               i_cmd,
    output tssr_pkg::t_status            o_status,
    input  logic [1:0]                   i_operation,
    input  logic [12:0]                  i_address,
    input  logic [7:0]                   i_data,
    input  logic [7:0]                   i_row,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [15:0]                  o_pixel_group,
    output logic [4:0]                   o_group_index,
    output logic                         o_last_group,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tssr_pkg::CFG_AW-1:0]  paddr,
    input  logic [tssr_pkg::CFG_DW-1:0]  pwdata,
    output logic [tssr_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int NG       = (LINE_WIDTH + 7) / 8;
    localparam int LBD      = NG * 8;
    localparam int LBW      = $clog2(LBD);
    localparam int CW       = $clog2(LINE_WIDTH);
    localparam int OAM_SIZE = SPRITE_COUNT * 4;
    localparam int OAW      = $clog2(OAM_SIZE);
    localparam int SIW      = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int GW       = (NG > 1) ? $clog2(NG) : 1;

    function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] idx);
        logic [1:0] s;
        case (idx)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

    // configuration registers
    logic [7:0] r_lcdc, r_scy, r_scx, r_bgp, r_obp0, r_obp1;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0; r_scy <= '0; r_scx <= '0;
            r_bgp  <= '0; r_obp0 <= '0; r_obp1 <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                tssr_pkg::REG_LCDC: r_lcdc <= pwdata[7:0];
                tssr_pkg::REG_SCY:  r_scy  <= pwdata[7:0];
                tssr_pkg::REG_SCX:  r_scx  <= pwdata[7:0];
                tssr_pkg::REG_BGP:  r_bgp  <= pwdata[7:0];
                tssr_pkg::REG_OBP0: r_obp0 <= pwdata[7:0];
                tssr_pkg::REG_OBP1: r_obp1 <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tssr_pkg::REG_LCDC: prdata = {24'd0, r_lcdc};
            tssr_pkg::REG_SCY:  prdata = {24'd0, r_scy};
            tssr_pkg::REG_SCX:  prdata = {24'd0, r_scx};
            tssr_pkg::REG_BGP:  prdata = {24'd0, r_bgp};
            tssr_pkg::REG_OBP0: prdata = {24'd0, r_obp0};
            tssr_pkg::REG_OBP1: prdata = {24'd0, r_obp1};
            default:            prdata = '0;
        endcase
    end

    // counters and captured values
    logic [12:0]    r_clr;
    logic [7:0]     r_row;
    logic [CW-1:0]  r_col;
    logic [SIW-1:0] r_spr;
    logic [2:0]     r_k;
    logic [GW-1:0]  r_grp;
    logic [12:0]    r_laddr;
    logic [7:0]     r_lo, r_hi, r_sy, r_sx, r_tile, r_attr;
    logic [15:0]    r_word;

    // memories and their registered read data
    logic [7:0] vram [2**tssr_pkg::VMEM_AW];
    logic [7:0] oam  [OAM_SIZE];
    logic [3:0] lbuf [LBD];
    logic [7:0] r_vrd, r_ord;
    logic [3:0] r_lrd;

    logic        v_we;
    logic [12:0] v_wa, v_ra;
    logic [7:0]  v_wd;
    logic        o_we;
    logic [OAW-1:0] o_wa, o_ra;
    logic [7:0]  o_wd;
    logic        l_we;
    logic [LBW-1:0] l_wa, l_ra;
    logic [3:0]  l_wd;

    always_ff @(posedge i_clk) begin
        if (v_we) vram[v_wa] <= v_wd;
        r_vrd <= vram[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (o_we) oam[o_wa] <= o_wd;
        r_ord <= oam[o_ra];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) lbuf[l_wa] <= l_wd;
        r_lrd <= lbuf[l_ra];
    end

    // background addressing
    logic [7:0]  bgy, bgx;
    logic [12:0] map_addr, bg_line_addr;
    logic        signed_set;
    logic [2:0]  bg_bit;
    logic [1:0]  bg_idx, bg_shade;

    assign bgy        = r_scy + r_row;
    assign bgx        = r_scx + 8'(r_col);
    assign map_addr   = (r_lcdc[tssr_pkg::LCDC_MAP] ? tssr_pkg::MAP_HIGH_OFS
                                                    : tssr_pkg::MAP_LOW_OFS)
                        | {3'd0, bgy[7:3], bgx[7:3]};
    // signed set: tiles 0..127 sit at 0x9000, 128..255 below it
    assign signed_set   = !r_lcdc[tssr_pkg::LCDC_TILES] && !r_vrd[7];
    assign bg_line_addr = {signed_set, r_vrd, bgy[2:0], 1'b0};
    assign bg_bit       = ~bgx[2:0];
    assign bg_idx       = r_lcdc[tssr_pkg::LCDC_BG_EN] ? {r_vrd[bg_bit], r_lo[bg_bit]} : 2'd0;
    assign bg_shade     = r_lcdc[tssr_pkg::LCDC_BG_EN] ? pal_shade(r_bgp, bg_idx) : 2'd0;

    // sprite row test and pixel
    logic [9:0]  dy, cc;
    logic        hit, onscreen, show;
    logic [2:0]  ty, tx, sp_bit;
    logic [12:0] sp_line_addr;
    logic [1:0]  sp_v;
    logic [7:0]  sp_pal;

    assign dy           = 10'(r_row) + 10'd16 - 10'(r_sy);
    assign hit          = (dy[9:3] == 7'd0);
    assign ty           = dy[2:0] ^ {3{r_ord[tssr_pkg::ATTR_YFLIP]}};
    assign sp_line_addr = {1'b0, r_tile, ty, 1'b0};
    assign cc           = 10'(r_sx) + 10'(r_k) - 10'd8;
    assign onscreen     = !cc[9] && (cc < 10'(LINE_WIDTH));
    assign tx           = r_k ^ {3{r_attr[tssr_pkg::ATTR_XFLIP]}};
    assign sp_bit       = ~tx;
    assign sp_v         = {r_hi[sp_bit], r_lo[sp_bit]};
    assign sp_pal       = r_attr[tssr_pkg::ATTR_PAL] ? r_obp1 : r_obp0;
    assign show         = (sp_v != 2'd0)
                          && !(r_attr[tssr_pkg::ATTR_BEHIND] && (r_lrd[3:2] != 2'd0));

    // readout position
    logic [LBW-1:0] pos;
    logic           pos_in;
    logic           out_free;
    assign pos      = LBW'({r_grp, r_k});
    assign pos_in   = (9'(pos) < 9'(LINE_WIDTH));
    assign out_free = !o_out_valid || i_out_ready;

    logic [OAW-1:0] spr_base;
    assign spr_base = OAW'({r_spr, 2'b00});

    always_comb begin
        v_we = 1'b0; v_wa = i_address; v_wd = i_data; v_ra = map_addr;
        o_we = 1'b0; o_wa = i_address[OAW-1:0]; o_wd = i_data; o_ra = spr_base;
        l_we = 1'b0; l_wa = LBW'(r_col); l_wd = {bg_idx, bg_shade}; l_ra = pos;
        case (i_cmd)
            tssr_pkg::CMD_CLR: begin
                v_we = 1'b1; v_wa = r_clr; v_wd = 8'd0;
                o_we = (r_clr < 13'(OAM_SIZE)); o_wa = r_clr[OAW-1:0]; o_wd = 8'd0;
            end
            tssr_pkg::CMD_ACCEPT: begin
                v_we = (i_operation == tssr_pkg::OP_VRAM);
                o_we = (i_operation == tssr_pkg::OP_OAM) && (i_address < 13'(OAM_SIZE));
            end
            tssr_pkg::CMD_BG_LO:  v_ra = bg_line_addr;
            tssr_pkg::CMD_BG_HI:  v_ra = r_laddr + 13'd1;
            tssr_pkg::CMD_BG_WR:  l_we = 1'b1;
            tssr_pkg::CMD_SP_Y:   o_ra = spr_base;
            tssr_pkg::CMD_SP_X:   o_ra = spr_base | OAW'(1);
            tssr_pkg::CMD_SP_T:   o_ra = spr_base | OAW'(2);
            tssr_pkg::CMD_SP_A:   o_ra = spr_base | OAW'(3);
            tssr_pkg::CMD_SP_CHK: v_ra = sp_line_addr;
            tssr_pkg::CMD_SP_LO:  v_ra = r_laddr + 13'd1;
            tssr_pkg::CMD_PX_RD:  l_ra = LBW'(cc);
            tssr_pkg::CMD_PX_WR: begin
                l_wa = LBW'(cc);
                l_wd = {r_lrd[3:2], pal_shade(sp_pal, sp_v)};
                l_we = show;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd == tssr_pkg::CMD_CLR) r_clr <= r_clr + 13'd1;
            if (i_cmd == tssr_pkg::CMD_OUT_PUSH && out_free) o_out_valid <= 1'b1;
            else if (i_out_ready)                           o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            tssr_pkg::CMD_ACCEPT: begin
                r_row <= i_row; r_col <= '0; r_spr <= '0; r_k <= '0; r_grp <= '0;
            end
            tssr_pkg::CMD_BG_LO:  r_laddr <= bg_line_addr;
            tssr_pkg::CMD_BG_HI:  r_lo <= r_vrd;
            tssr_pkg::CMD_BG_WR:  r_col <= r_col + 1'b1;
            tssr_pkg::CMD_SP_X:   r_sy <= r_ord;
            tssr_pkg::CMD_SP_T:   r_sx <= r_ord;
            tssr_pkg::CMD_SP_A:   r_tile <= r_ord;
            tssr_pkg::CMD_SP_CHK: begin
                r_attr  <= r_ord;
                r_laddr <= sp_line_addr;
                if (!hit) r_spr <= r_spr + 1'b1;
            end
            tssr_pkg::CMD_SP_LO:  r_lo <= r_vrd;
            tssr_pkg::CMD_SP_HI:  begin r_hi <= r_vrd; r_k <= '0; end
            tssr_pkg::CMD_PX_RD: begin
                if (!onscreen) begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) r_spr <= r_spr + 1'b1;
                end
            end
            tssr_pkg::CMD_PX_WR: begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd7) r_spr <= r_spr + 1'b1;
            end
            tssr_pkg::CMD_OUT_CAP: begin
                r_word <= {r_word[13:0], pos_in ? r_lrd[1:0] : 2'd0};
                r_k    <= r_k + 3'd1;
            end
            tssr_pkg::CMD_OUT_PUSH: begin
                if (out_free) begin
                    o_pixel_group <= r_word;
                    o_group_index <= 5'(r_grp);
                    o_last_group  <= (r_grp == GW'(NG - 1));
                    r_grp         <= r_grp + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_status.clr_done = (r_clr == tssr_pkg::VMEM_LAST);
    assign o_status.in_op    = tssr_pkg::t_op'(i_operation);
    assign o_status.spr_en   = r_lcdc[tssr_pkg::LCDC_OBJ_EN];
    assign o_status.col_last = (r_col == CW'(LINE_WIDTH - 1));
    assign o_status.spr_last = (r_spr == SIW'(SPRITE_COUNT - 1));
    assign o_status.spr_hit  = hit;
    assign o_status.px_skip  = !onscreen;
    assign o_status.k_last   = (r_k == 3'd7);
    assign o_status.grp_last = (r_grp == GW'(NG - 1));
    assign o_status.out_free = out_free;

endmodule

>>> rtl/core/tile_sprite_scanline_renderer.sv
// Top level of the tile and sprite scanline renderer.
// Write requests (video memory or sprite table) are taken in the idle state. A render request
// builds the row in a line buffer and then sends it as eight-pixel groups: per column the
// background reads the map byte and two tile bytes, all through the single read port of video
// memory, then writes the line buffer; per sprite the four attribute bytes are read, and a
// sprite that covers the row has its two tile bytes read and then each on-screen pixel read
// from the line buffer and, where shown, written back; readout reads and captures each pixel
// and pushes each finished group. After reset a clearing pass zeroes video memory and the
// sprite table; no request is taken meanwhile, though configuration writes are. A finished
// group waits in the output register while the next is assembled.
module tile_sprite_scanline_renderer #(
    parameter int LINE_WIDTH   = tssr_pkg::LINE_WIDTH_DEF,
    parameter int SPRITE_COUNT = tssr_pkg::SPRITE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_operation,
    input  logic [12:0]                  i_address,
    input  logic [7:0]                   i_data,
    input  logic [7:0]                   i_row,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [15:0]                  o_pixel_group,
    output logic [4:0]                   o_group_index,
    output logic                         o_last_group,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tssr_pkg::CFG_AW-1:0]  paddr,
    input  logic [tssr_pkg::CFG_DW-1:0]  pwdata,
    output logic [tssr_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);

    tssr_pkg::t_cmd    cmd;
    tssr_pkg::t_status status;

    // sequencer: steps through clear, background, sprites and readout
    tssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memories, registers and pixel logic
    tssr_datapath #(
        .LINE_WIDTH   (LINE_WIDTH),
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_operation),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_row         (i_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_group (o_pixel_group),
        .o_group_index (o_group_index),
        .o_last_group  (o_last_group),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

endmodule

>>> rtl/core/tssr_checker.sv
// Port-level checks of the scanline renderer and their binding to the top level.
module tssr_checker #(
    parameter int LINE_WIDTH = tssr_pkg::LINE_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_pixel_group,
    input logic [4:0]  o_group_index,
    input logic        o_last_group
);

    localparam int NG = (LINE_WIDTH + 7) / 8;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_group)
            && $stable(o_group_index) && $stable(o_last_group))
        else $error("stalled result changed");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_group |-> o_group_index == 5'(NG - 1))
        else $error("last group flag on wrong index");

    a_mid_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_group |-> o_group_index < 5'(NG - 1))
        else $error("group index past the last group");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("request taken during clearing pass");

endmodule

bind tile_sprite_scanline_renderer tssr_checker #(.LINE_WIDTH(LINE_WIDTH)) u_tssr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_group (o_pixel_group),
    .o_group_index (o_group_index),
    .o_last_group  (o_last_group)
);
